/* sv/gms_pkg.sv */
// ----------------------------------------------------------------------------
// gms_pkg: shared types and constants
// Control codes, register indexes and the sequencer state type for the
// gradient magnitude stencil core.
// ----------------------------------------------------------------------------
`default_nettype none

package gms_pkg;

   // fixed field widths
   localparam int GRAD_W = 19;
   localparam int DIM_W  = 7;
   localparam int CSR_IDX_W = 2;

   // command codes on the request channel
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   // register reset values
   localparam logic [DIM_W-1:0] RST_SIZE_X = 7'd64;
   localparam logic [DIM_W-1:0] RST_SIZE_Y = 7'd64;
   localparam logic [DIM_W-1:0] RST_SIZE_Z = 7'd0;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_HI,
      ST_RD_LO,
      ST_DIFF,
      ST_SQUARE,
      ST_ROOT_GO,
      ST_ROOT,
      ST_PUT
   } state_type;

   // control into and status out of the root unit
   typedef struct packed {
      logic start;
   } root_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } root_sts_type;

endpackage

`default_nettype wire

/* sv/gms_if.sv */
// ----------------------------------------------------------------------------
// gms_if: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gms_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface gms_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [gms_pkg::GRAD_W-1:0] grad;
   logic                              last;

   modport source (output valid, output grad, output last, input ready);
   modport sink   (input valid, input grad, input last, output ready);
endinterface

`default_nettype wire

/* sv/gms_ram.sv */
// ----------------------------------------------------------------------------
// gms_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8193
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/gms_isqrt.sv */
// ----------------------------------------------------------------------------
// gms_isqrt: iterative integer square root
// Digit-by-digit floor root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_isqrt #(
   parameter int RES_W = 18
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gms_pkg::root_ctl_type ctl,
   input  wire logic [2*RES_W-1:0]    radicand,
   output      gms_pkg::root_sts_type sts,
   output      logic [RES_W-1:0]      root
);

   localparam int OW = 2 * RES_W;
   localparam int CW = $clog2(RES_W + 1);

   logic [OW-1:0] op_ff, op_in;
   logic [OW-1:0] res_ff, res_in;
   logic [OW-1:0] one_ff, one_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [OW-1:0] trial;

   // one step of the restoring root
   always_comb begin
      trial   = res_ff + one_ff;
      op_in   = op_ff;
      res_in  = res_ff;
      one_in  = one_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         op_in   = radicand;
         res_in  = '0;
         one_in  = OW'(1) << (OW - 2);
         cnt_in  = CW'(RES_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff >= trial) begin
            op_in  = op_ff - trial;
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in = one_ff >> 2;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff  <= op_in;
      res_ff <= res_in;
      one_ff <= one_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign root     = res_ff[RES_W-1:0];

endmodule

`default_nettype wire

/* sv/gradient_magnitude_stencil_core.sv */
// ----------------------------------------------------------------------------
// gradient_magnitude_stencil_core: streaming gradient magnitude
// Central-difference gradient of a 1D/2D/3D raster volume, in Q.1.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one beat per sample (cmd = sample) or flush tick.
//   rsp_ch returns at most one beat per request: the gradient of point p,
//   released by the beat carrying sample p+S (S = 1, a row or a plane),
//   or by a flush tick once the volume is complete. last marks the final
//   point; the point counters then restart for the next volume.
//   csr_* writes size_x/size_y/size_z; any write to them restarts the volume.
//   Write only while idle; after a write the block takes no request beat
//   until the derived sizes pass the clamp, plane and total stages.
// Flow: one request at a time; no new beat is taken until the last is done.
//   A beat with no result returns to idle after the check; one with a
//   result reads both neighbours, differences and squares them per axis,
//   and in 2D/3D then runs the iterative root before it is put out. The
//   window RAM read port (one sample per cycle) and the root unit set this pace.
// Reset clears counters and sizes to 64 x 64 x 0 (2D); RAM contents are
//   not cleared. A finished result sits in the output register while the
//   next request is processed; a stalled receiver holds the core only
//   when a second result is ready to go.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_magnitude_stencil_core #(
   parameter int MAX_X       = 64,
   parameter int MAX_Y       = 64,
   parameter int MAX_Z       = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   gms_req_if.sink                               req_ch,
   gms_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [gms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gms_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int RW    = SB + 2;
   localparam int SW    = 2 * RW;
   localparam int DEPTH = 2 * MAX_X * MAX_Y + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_X + 1);
   localparam int YW    = $clog2(MAX_Y + 1);
   localparam int ZW    = $clog2(MAX_Z + 1);
   localparam int PW    = $clog2(MAX_X * MAX_Y + 1);
   localparam int CW    = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
   localparam int GW    = (RW > gms_pkg::GRAD_W) ? RW : gms_pkg::GRAD_W;
   localparam logic [AW:0] DEPTH_L = (AW+1)'(DEPTH);

   // configuration registers and derived sizes
   logic [gms_pkg::DIM_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [XW-1:0] nx_ff, nx_in;
   logic [YW-1:0] ny_ff, ny_in;
   logic [ZW-1:0] nz_ff, nz_in;
   logic [PW-1:0] plane_ff, stride_ff, stride_in;
   logic [CW-1:0] total_ff, total_in;
   logic [1:0]    axes_ff, axes_in;
   logic [1:0]    settle_ff;
   logic          csr_hit;

   // stream counters
   logic [CW-1:0] in_count_ff, out_count_ff;
   logic [AW-1:0] wr_ptr_ff, p_ff;
   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic [ZW-1:0] z_ff;

   // sequencer
   gms_pkg::state_type state_ff, state_in;
   logic [1:0]          ax_ff;
   logic signed [SB-1:0] hi_ff;
   logic signed [RW-1:0] comp_ff;
   logic [RW-1:0]       abs_ff;
   logic [SW-1:0]       sum_ff;

   // output register
   logic                              rsp_valid_ff;
   logic signed [gms_pkg::GRAD_W-1:0] grad_ff;
   logic                              last_ff;

   // FSM outputs
   logic                  accept, do_write, load, emit_ok, fin;
   logic [AW-1:0]         rd_addr;
   logic [SB-1:0]         rd_data;
   gms_pkg::root_ctl_type root_ctl;
   gms_pkg::root_sts_type root_sts;
   logic [RW-1:0]         root;

   // ------------------------------------------------------------------
   // config: raw registers, then clamp, plane and total stages
   // ------------------------------------------------------------------
   assign csr_hit = csr_we && (csr_index == gms_pkg::CSR_SIZE_X ||
                               csr_index == gms_pkg::CSR_SIZE_Y ||
                               csr_index == gms_pkg::CSR_SIZE_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= gms_pkg::RST_SIZE_X;
         size_y_ff <= gms_pkg::RST_SIZE_Y;
         size_z_ff <= gms_pkg::RST_SIZE_Z;
         settle_ff <= 2'd3;
      end else begin
         if (csr_we) begin
            case (csr_index)
               gms_pkg::CSR_SIZE_X: size_x_ff <= csr_wdata;
               gms_pkg::CSR_SIZE_Y: size_y_ff <= csr_wdata;
               gms_pkg::CSR_SIZE_Z: size_z_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (csr_hit) begin
            settle_ff <= 2'd3;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // clamp each dimension; a zero y or z size selects a lower rank
   always_comb begin
      if (size_x_ff < 7'd2)              nx_in = XW'(2);
      else if (int'(size_x_ff) > MAX_X)  nx_in = XW'(MAX_X);
      else                               nx_in = XW'(size_x_ff);
      if (size_y_ff == 7'd0)             ny_in = '0;
      else if (size_y_ff < 7'd2)         ny_in = YW'(2);
      else if (int'(size_y_ff) > MAX_Y)  ny_in = YW'(MAX_Y);
      else                               ny_in = YW'(size_y_ff);
      if (size_y_ff == 7'd0 || size_z_ff == 7'd0) nz_in = '0;
      else if (size_z_ff < 7'd2)         nz_in = ZW'(2);
      else if (int'(size_z_ff) > MAX_Z)  nz_in = ZW'(MAX_Z);
      else                               nz_in = ZW'(size_z_ff);
   end

   // totals and strides by rank
   always_comb begin
      if (ny_ff == '0) begin
         total_in  = CW'(nx_ff);
         stride_in = PW'(1);
         axes_in   = 2'd1;
      end else if (nz_ff == '0) begin
         total_in  = CW'(plane_ff);
         stride_in = PW'(nx_ff);
         axes_in   = 2'd2;
      end else begin
         total_in  = CW'(plane_ff) * CW'(nz_ff);
         stride_in = plane_ff;
         axes_in   = 2'd3;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
      plane_ff  <= PW'(nx_ff) * PW'(ny_ff);
      total_ff  <= total_in;
      stride_ff <= stride_in;
      axes_ff   <= axes_in;
   end

   // ------------------------------------------------------------------
   // window RAM
   // ------------------------------------------------------------------
   assign accept   = req_ch.valid && req_ch.ready;
   assign do_write = accept && (req_ch.cmd == gms_pkg::CMD_SAMPLE) &&
                     (in_count_ff < total_ff);

   gms_ram #(
      .WIDTH (SB),
      .DEPTH (DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_ch.sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // per-axis neighbor addresses (modulo the window depth)
   // ------------------------------------------------------------------
   logic [PW-1:0] s_sel;
   logic          at_first, at_last, at_face;
   logic [AW:0]   plus_w, minus_w;
   logic [AW-1:0] hi_addr, lo_addr;

   always_comb begin
      case (ax_ff)
         2'd0: begin
            s_sel    = PW'(1);
            at_first = (x_ff == '0);
            at_last  = (x_ff == nx_ff - XW'(1));
         end
         2'd1: begin
            s_sel    = PW'(nx_ff);
            at_first = (y_ff == '0);
            at_last  = (y_ff == ny_ff - YW'(1));
         end
         default: begin
            s_sel    = plane_ff;
            at_first = (z_ff == '0);
            at_last  = (z_ff == nz_ff - ZW'(1));
         end
      endcase
      at_face = at_first || at_last;
      plus_w  = (AW+1)'(p_ff) + (AW+1)'(s_sel);
      if (plus_w >= DEPTH_L) plus_w = plus_w - DEPTH_L;
      if ((AW+1)'(p_ff) >= (AW+1)'(s_sel)) begin
         minus_w = (AW+1)'(p_ff) - (AW+1)'(s_sel);
      end else begin
         minus_w = (AW+1)'(p_ff) + DEPTH_L - (AW+1)'(s_sel);
      end
      hi_addr = at_last  ? p_ff : plus_w[AW-1:0];
      lo_addr = at_first ? p_ff : minus_w[AW-1:0];
   end

   // ------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      emit_ok = (out_count_ff < total_ff) &&
                ((CW+1)'(out_count_ff) + (CW+1)'(stride_ff) < (CW+1)'(in_count_ff) ||
                 in_count_ff >= total_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gms_pkg::ST_IDLE:    if (accept) state_in = gms_pkg::ST_CHECK;
         gms_pkg::ST_CHECK:   state_in = emit_ok ? gms_pkg::ST_RD_HI : gms_pkg::ST_IDLE;
         gms_pkg::ST_RD_HI:   state_in = gms_pkg::ST_RD_LO;
         gms_pkg::ST_RD_LO:   state_in = gms_pkg::ST_DIFF;
         gms_pkg::ST_DIFF:    state_in = gms_pkg::ST_SQUARE;
         gms_pkg::ST_SQUARE: begin
            if (ax_ff + 2'd1 < axes_ff)    state_in = gms_pkg::ST_RD_HI;
            else if (axes_ff == 2'd1)      state_in = gms_pkg::ST_PUT;
            else                           state_in = gms_pkg::ST_ROOT_GO;
         end
         gms_pkg::ST_ROOT_GO: state_in = gms_pkg::ST_ROOT;
         gms_pkg::ST_ROOT:    if (root_sts.done) state_in = gms_pkg::ST_PUT;
         gms_pkg::ST_PUT:     if (load) state_in = gms_pkg::ST_IDLE;
         default:             state_in = gms_pkg::ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ch.ready   = (state_ff == gms_pkg::ST_IDLE) && (settle_ff == 2'd0);
      rd_addr        = (state_ff == gms_pkg::ST_RD_LO) ? lo_addr : hi_addr;
      root_ctl.start = (state_ff == gms_pkg::ST_ROOT_GO);
      load           = (state_ff == gms_pkg::ST_PUT) && (!rsp_valid_ff || rsp_ch.ready);
      fin            = (out_count_ff + CW'(1) == total_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gms_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // ------------------------------------------------------------------
   // datapath: difference, square, accumulate
   // ------------------------------------------------------------------
   logic signed [SB:0]   diff;
   logic signed [RW-1:0] comp;
   logic [SW-1:0]        sq;

   always_comb begin
      diff = $signed({hi_ff[SB-1], hi_ff}) - $signed({rd_data[SB-1], rd_data});
      comp = at_face ? $signed({diff, 1'b0}) : $signed({diff[SB], diff});
      sq   = SW'(abs_ff) * SW'(abs_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == gms_pkg::ST_CHECK) begin
         ax_ff  <= 2'd0;
         sum_ff <= '0;
      end
      if (state_ff == gms_pkg::ST_RD_LO) hi_ff <= $signed(rd_data);
      if (state_ff == gms_pkg::ST_DIFF) begin
         if (ax_ff == 2'd0) comp_ff <= comp;
         abs_ff <= comp[RW-1] ? RW'(-comp) : RW'(comp);
      end
      if (state_ff == gms_pkg::ST_SQUARE) begin
         sum_ff <= sum_ff + sq;
         ax_ff  <= ax_ff + 2'd1;
      end
   end

   gms_isqrt #(
      .RES_W (RW)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .ctl      (root_ctl),
      .radicand (sum_ff),
      .sts      (root_sts),
      .root     (root)
   );

   // ------------------------------------------------------------------
   // output register and stream counters
   // ------------------------------------------------------------------
   logic signed [GW-1:0] g_ext;

   always_comb begin
      if (axes_ff == 2'd1) g_ext = GW'(comp_ff);
      else                 g_ext = $signed(GW'(root));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         grad_ff <= g_ext[gms_pkg::GRAD_W-1:0];
         last_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit || (load && fin)) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         wr_ptr_ff    <= '0;
         p_ff         <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
      end else begin
         if (do_write) begin
            in_count_ff <= in_count_ff + CW'(1);
            wr_ptr_ff   <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (load) begin
            out_count_ff <= out_count_ff + CW'(1);
            p_ff         <= (p_ff == AW'(DEPTH - 1)) ? '0 : p_ff + AW'(1);
            if (x_ff == nx_ff - XW'(1)) begin
               x_ff <= '0;
               if (y_ff == ny_ff - YW'(1)) begin
                  y_ff <= '0;
                  z_ff <= z_ff + ZW'(1);
               end else begin
                  y_ff <= y_ff + YW'(1);
               end
            end else begin
               x_ff <= x_ff + XW'(1);
            end
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.grad  = grad_ff;
   assign rsp_ch.last  = last_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_in_bound: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == 2'd0) |-> (in_count_ff <= total_ff))
      else $error("sample count past volume size");

   a_out_le_in: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == 2'd0) |-> (out_count_ff <= in_count_ff))
      else $error("more results than samples");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (load && fin && !csr_we) |=> (in_count_ff == '0 && out_count_ff == '0))
      else $error("counters not cleared after final point");

   a_root_state: assert property (@(posedge clock) disable iff (reset)
      root_sts.busy |-> (state_ff == gms_pkg::ST_ROOT))
      else $error("root unit busy outside root wait");

endmodule

`default_nettype wire
